### rtl/control_channel_fsm_top_assert.svh
// ---------------------------------------------------------------------------
// Control channel FSM assertion macros
// Clocked property checks, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef CONTROL_CHANNEL_FSM_TOP_ASSERT_SVH
`define CONTROL_CHANNEL_FSM_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define CCF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define CCF_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define CCF_ASSERT(label, prop, msg)
`define CCF_ASSERT_RST(label, prop, msg)
`endif

`endif

### rtl/ccf_pkg.sv
// ---------------------------------------------------------------------------
// Control channel FSM package
// State and event codes, action flags and the step result type.
// ---------------------------------------------------------------------------
package ccf_pkg;

   localparam int unsigned OP_W = 5;

   typedef enum logic [2:0] {
      ST_DOWN      = 3'd0,
      ST_CONFSND   = 3'd1,
      ST_CONFRCV   = 3'd2,
      ST_ACTIVE    = 3'd3,
      ST_UP        = 3'd4,
      ST_GOINGDOWN = 3'd5
   } state_type;

   localparam logic [OP_W-1:0] EV_BRINGUP     = 5'd0;
   localparam logic [OP_W-1:0] EV_CCDOWN      = 5'd1;
   localparam logic [OP_W-1:0] EV_CONFDONE    = 5'd2;
   localparam logic [OP_W-1:0] EV_CONFERR     = 5'd3;
   localparam logic [OP_W-1:0] EV_NEWCONFOK   = 5'd4;
   localparam logic [OP_W-1:0] EV_NEWCONFERR  = 5'd5;
   localparam logic [OP_W-1:0] EV_CONTENWIN   = 5'd6;
   localparam logic [OP_W-1:0] EV_CONTENLOST  = 5'd7;
   localparam logic [OP_W-1:0] EV_ADMINDOWN   = 5'd8;
   localparam logic [OP_W-1:0] EV_NBRGOESDOWN = 5'd9;
   localparam logic [OP_W-1:0] EV_HELLORCVD   = 5'd10;
   localparam logic [OP_W-1:0] EV_HOLDTIMER   = 5'd11;
   localparam logic [OP_W-1:0] EV_SEQNUMERR   = 5'd12;
   localparam logic [OP_W-1:0] EV_RECONFIG    = 5'd13;
   localparam logic [OP_W-1:0] EV_CONFRET     = 5'd14;
   localparam logic [OP_W-1:0] EV_HELLORET    = 5'd15;
   localparam logic [OP_W-1:0] EV_DOWNTIMER   = 5'd16;

   typedef struct packed {
      logic set_down_flag;
      logic stop_hello;
      logic send_hello;
      logic send_nack;
      logic send_ack;
      logic resend_config;
      logic stop_config;
      logic send_config;
   } action_type;

   typedef struct packed {
      state_type  new_state;
      logic       hit;
      action_type act;
   } step_type;

endpackage

### rtl/ccf_req_if.sv
// ---------------------------------------------------------------------------
// Control channel FSM request interface
// Event transfer: valid, ready and the event payload.
// ---------------------------------------------------------------------------
interface ccf_req_if;
   logic       valid;
   logic       ready;
   logic [4:0] operation;
   logic       config_acceptable;

   modport source (output valid, output operation, output config_acceptable, input ready);
   modport sink   (input valid, input operation, input config_acceptable, output ready);
endinterface

### rtl/ccf_rsp_if.sv
// ---------------------------------------------------------------------------
// Control channel FSM response interface
// Result transfer: valid, ready, new state and action flags.
// ---------------------------------------------------------------------------
interface ccf_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] new_state;
   logic       transition_taken;
   logic       do_send_config;
   logic       do_stop_config;
   logic       do_resend_config;
   logic       do_send_ack;
   logic       do_send_nack;
   logic       do_send_hello;
   logic       do_stop_hello;
   logic       do_set_down_flag;

   modport source (
      output valid, output new_state, output transition_taken,
      output do_send_config, output do_stop_config, output do_resend_config,
      output do_send_ack, output do_send_nack, output do_send_hello,
      output do_stop_hello, output do_set_down_flag, input ready
   );
   modport sink (
      input valid, input new_state, input transition_taken,
      input do_send_config, input do_stop_config, input do_resend_config,
      input do_send_ack, input do_send_nack, input do_send_hello,
      input do_stop_hello, input do_set_down_flag, output ready
   );
endinterface

### rtl/ccf_lookup.sv
// ---------------------------------------------------------------------------
// Control channel FSM transition lookup
// Maps current state, event, role and acceptability to next state and actions.
// ---------------------------------------------------------------------------
module ccf_lookup (
   input  ccf_pkg::state_type state_cur,
   input  logic [4:0]         operation,
   input  logic               config_acceptable,
   input  logic               role,
   output ccf_pkg::step_type  step
);
   import ccf_pkg::*;

   always_comb begin
      step           = '0;
      step.new_state = state_cur;
      case (state_cur)
         ST_DOWN: begin
            if (operation == EV_BRINGUP) begin
               step.hit = 1'b1;
               if (role) begin
                  step.new_state       = ST_CONFSND;
                  step.act.send_config = 1'b1;
               end else begin
                  step.new_state = ST_CONFRCV;
               end
            end
         end
         ST_CONFSND: begin
            case (operation)
               EV_CCDOWN, EV_ADMINDOWN: begin
                  step.hit             = 1'b1;
                  step.new_state       = ST_DOWN;
                  step.act.stop_config = 1'b1;
               end
               EV_CONFERR, EV_RECONFIG: begin
                  step.hit             = 1'b1;
                  step.act.send_config = 1'b1;
               end
               EV_CONTENWIN: begin
                  step.hit = 1'b1;
               end
               EV_CONFRET: begin
                  step.hit               = 1'b1;
                  step.act.resend_config = 1'b1;
               end
               EV_CONTENLOST: begin
                  step.hit             = 1'b1;
                  step.act.stop_config = 1'b1;
                  if (config_acceptable) begin
                     step.new_state      = ST_ACTIVE;
                     step.act.send_ack   = 1'b1;
                     step.act.send_hello = 1'b1;
                  end else begin
                     step.new_state     = ST_CONFRCV;
                     step.act.send_nack = 1'b1;
                  end
               end
               EV_CONFDONE: begin
                  step.hit             = 1'b1;
                  step.new_state       = ST_ACTIVE;
                  step.act.stop_config = 1'b1;
                  step.act.send_hello  = 1'b1;
               end
               default: ;
            endcase
         end
         ST_CONFRCV: begin
            case (operation)
               EV_CCDOWN, EV_ADMINDOWN: begin
                  step.hit       = 1'b1;
                  step.new_state = ST_DOWN;
               end
               EV_CONFERR: begin
                  step.hit           = 1'b1;
                  step.act.send_nack = 1'b1;
               end
               EV_RECONFIG: begin
                  step.hit = 1'b1;
               end
               EV_NEWCONFOK: begin
                  step.hit            = 1'b1;
                  step.new_state      = ST_ACTIVE;
                  step.act.send_ack   = 1'b1;
                  step.act.send_hello = 1'b1;
               end
               default: ;
            endcase
         end
         ST_ACTIVE, ST_UP: begin
            case (operation)
               EV_CCDOWN, EV_NBRGOESDOWN: begin
                  step.hit            = 1'b1;
                  step.new_state      = ST_DOWN;
                  step.act.stop_hello = 1'b1;
               end
               EV_ADMINDOWN: begin
                  step.hit               = 1'b1;
                  step.new_state         = ST_GOINGDOWN;
                  step.act.set_down_flag = 1'b1;
               end
               EV_RECONFIG: begin
                  step.hit             = 1'b1;
                  step.new_state       = ST_CONFSND;
                  step.act.send_config = 1'b1;
                  step.act.stop_hello  = 1'b1;
               end
               EV_HOLDTIMER: begin
                  step.hit            = 1'b1;
                  step.act.stop_hello = 1'b1;
                  if (role) begin
                     step.new_state       = ST_CONFSND;
                     step.act.send_config = 1'b1;
                  end else begin
                     step.new_state = ST_CONFRCV;
                  end
               end
               EV_NEWCONFERR: begin
                  step.hit            = 1'b1;
                  step.new_state      = ST_CONFRCV;
                  step.act.send_nack  = 1'b1;
                  step.act.stop_hello = 1'b1;
               end
               EV_NEWCONFOK: begin
                  step.hit       = 1'b1;
                  step.new_state = ST_ACTIVE;
               end
               EV_SEQNUMERR: begin
                  step.hit = 1'b1;
               end
               EV_HELLORET: begin
                  step.hit            = 1'b1;
                  step.act.send_hello = 1'b1;
               end
               EV_HELLORCVD: begin
                  step.hit       = 1'b1;
                  step.new_state = ST_UP;
               end
               default: ;
            endcase
         end
         ST_GOINGDOWN: begin
            if (operation == EV_NBRGOESDOWN || operation == EV_DOWNTIMER) begin
               step.hit            = 1'b1;
               step.new_state      = ST_DOWN;
               step.act.stop_hello = 1'b1;
            end
         end
         default: ;
      endcase
   end

endmodule

### rtl/control_channel_fsm_top.sv
// One event per transfer, one result per event. The result appears in the
// output register the cycle after the event transfer, and a new event is taken
// every cycle as long as the output register is empty or being drained in the same
// cycle; the single output register sets that one-per-cycle rate. The channel state
// starts in Down after reset. csr_wdata selects the setup role (1 active, 0 passive);
// the user must write it only while no result is pending; the block does not enforce it.
// ---------------------------------------------------------------------------
// Control channel FSM top level
// Link-management control channel state machine with registered result.
// ---------------------------------------------------------------------------
`include "control_channel_fsm_top_assert.svh"

module control_channel_fsm_top (
   input  logic     clock,
   input  logic     reset,
   input  logic     csr_we,
   input  logic     csr_wdata,
   ccf_req_if.sink  req_chan,
   ccf_rsp_if.source rsp_chan
);
   import ccf_pkg::*;

   state_type state_ff, state_in;
   logic      role_ff, role_in;
   logic      rsp_valid_ff, rsp_valid_in;
   step_type  rsp_ff, rsp_in;
   step_type  step;
   logic      req_fire;

   ccf_lookup u_lookup (
      .state_cur         (state_ff),
      .operation         (req_chan.operation),
      .config_acceptable (req_chan.config_acceptable),
      .role              (role_ff),
      .step              (step)
   );

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_comb begin
      state_in     = state_ff;
      role_in      = role_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (csr_we) begin
         role_in = csr_wdata;
      end
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_fire) begin
         state_in     = step.new_state;
         rsp_in       = step;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_DOWN;
         role_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         role_ff      <= role_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.new_state        = rsp_ff.new_state;
   assign rsp_chan.transition_taken = rsp_ff.hit;
   assign rsp_chan.do_send_config   = rsp_ff.act.send_config;
   assign rsp_chan.do_stop_config   = rsp_ff.act.stop_config;
   assign rsp_chan.do_resend_config = rsp_ff.act.resend_config;
   assign rsp_chan.do_send_ack      = rsp_ff.act.send_ack;
   assign rsp_chan.do_send_nack     = rsp_ff.act.send_nack;
   assign rsp_chan.do_send_hello    = rsp_ff.act.send_hello;
   assign rsp_chan.do_stop_hello    = rsp_ff.act.stop_hello;
   assign rsp_chan.do_set_down_flag = rsp_ff.act.set_down_flag;

   `CCF_ASSERT(a_state_tracks_rsp, req_fire |=> (state_ff == rsp_ff.new_state), "state and result disagree")
   `CCF_ASSERT(a_miss_no_action, (rsp_valid_ff && !rsp_ff.hit) |-> (rsp_ff.act == '0), "action on unmatched event")
   `CCF_ASSERT(a_stall_only_full, !req_chan.ready |-> (rsp_valid_ff && !rsp_chan.ready), "input stalled with room")
   `CCF_ASSERT_RST(a_reset_down, $past(reset) |-> (state_ff == ST_DOWN && !rsp_valid_ff), "not idle after reset")

endmodule
